[rtl/core/hrp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrp_pkg
// Shared types, phase codes, byte tags and character class functions of the
// HTTP response header parser.
// ----------------------------------------------------------------------------
package hrp_pkg;

    localparam logic [3:0] PH_LETTERS = 4'd0;
    localparam logic [3:0] PH_SLASH   = 4'd1;
    localparam logic [3:0] PH_MAJOR   = 4'd2;
    localparam logic [3:0] PH_DOT     = 4'd3;
    localparam logic [3:0] PH_MINOR   = 4'd4;
    localparam logic [3:0] PH_SP1     = 4'd5;
    localparam logic [3:0] PH_CODE    = 4'd6;
    localparam logic [3:0] PH_SP2     = 4'd7;
    localparam logic [3:0] PH_REASON  = 4'd8;
    localparam logic [3:0] PH_LF      = 4'd9;
    localparam logic [3:0] PH_LINE    = 4'd10;
    localparam logic [3:0] PH_KEY     = 4'd11;
    localparam logic [3:0] PH_SEPSP   = 4'd12;
    localparam logic [3:0] PH_VALUE   = 4'd13;
    localparam logic [3:0] PH_ENDLF   = 4'd14;
    localparam logic [3:0] PH_BODY    = 4'd15;

    localparam logic [3:0] CLS_VERSION  = 4'd0;
    localparam logic [3:0] CLS_CODE     = 4'd1;
    localparam logic [3:0] CLS_REASON   = 4'd2;
    localparam logic [3:0] CLS_LINE_END = 4'd3;
    localparam logic [3:0] CLS_KEY      = 4'd4;
    localparam logic [3:0] CLS_SEP      = 4'd5;
    localparam logic [3:0] CLS_VALUE    = 4'd6;
    localparam logic [3:0] CLS_HDR_END  = 4'd7;
    localparam logic [3:0] CLS_HDRS_END = 4'd8;
    localparam logic [3:0] CLS_BODY     = 4'd9;
    localparam logic [3:0] CLS_REJECT   = 4'd10;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_VERSION = 2'd1;
    localparam logic [1:0] ERR_STATUS  = 2'd2;
    localparam logic [1:0] ERR_HEADER  = 2'd3;

    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [1:0] CODE_DIGITS = 2'd3;
    localparam logic [7:0] HDR_MAX     = 8'hFF;

    typedef struct packed {
        logic [3:0] phase;
        logic [9:0] code_acc;
        logic [1:0] digit_cnt;
        logic [3:0] major;
        logic [3:0] minor;
        logic [7:0] hdr_cnt;
        logic [1:0] err;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:     PH_LETTERS,
        code_acc:  10'd0,
        digit_cnt: 2'd0,
        major:     4'd0,
        minor:     4'd0,
        hdr_cnt:   8'd0,
        err:       ERR_NONE
    };

    function automatic logic is_dec_char(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_text(input logic [7:0] c);
        return c inside {8'h09, [8'h20:8'h7E], [8'h80:8'hFF]};
    endfunction

    function automatic logic is_token(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                         8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A,
                         8'h2B, 8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C,
                         8'h7E};
    endfunction

endpackage
`default_nettype wire

[rtl/core/hrp_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hrp_step
// Next-state and byte tag logic: takes the parse state and one byte, gives
// the updated state, the byte tag and the header index seen by the byte.
// ----------------------------------------------------------------------------
module hrp_step
    import hrp_pkg::*;
(
    input  wire parse_state_t state,
    input  wire logic [7:0]   data_byte,
    input  wire logic         start_of_message,
    output parse_state_t      state_next,
    output logic [3:0]        byte_class,
    output logic [7:0]        header_index
);

    always_comb
    begin
        parse_state_t cur;
        logic [1:0]   fail;
        logic [7:0]   letter;
        logic [9:0]   acc_next;

        cur       = start_of_message ? STATE_RESET : state;
        fail      = ERR_NONE;
        state_next = cur;
        byte_class = CLS_REJECT;
        header_index = cur.hdr_cnt;

        case (cur.digit_cnt)
            2'd0:    letter = CH_H;
            2'd1:    letter = CH_T;
            2'd2:    letter = CH_T;
            default: letter = CH_P;
        endcase

        acc_next = {cur.code_acc[6:0], 3'b000} + {cur.code_acc[8:0], 1'b0}
                 + {6'd0, data_byte[3:0]};

        if (cur.err == ERR_NONE)
        begin
            case (cur.phase)
                PH_LETTERS:
                begin
                    if (data_byte == letter)
                    begin
                        byte_class = CLS_VERSION;
                        if (cur.digit_cnt == CODE_DIGITS)
                        begin
                            state_next.digit_cnt = 2'd0;
                            state_next.phase     = PH_SLASH;
                        end
                        else
                        begin
                            state_next.digit_cnt = cur.digit_cnt + 2'd1;
                        end
                    end
                    else
                    begin
                        fail = ERR_VERSION;
                    end
                end
                PH_SLASH:
                begin
                    if (data_byte == CH_SLASH)
                    begin
                        byte_class       = CLS_VERSION;
                        state_next.phase = PH_MAJOR;
                    end
                    else
                    begin
                        fail = ERR_VERSION;
                    end
                end
                PH_MAJOR:
                begin
                    if (is_dec_char(data_byte))
                    begin
                        byte_class       = CLS_VERSION;
                        state_next.major = data_byte[3:0];
                        state_next.phase = PH_DOT;
                    end
                    else
                    begin
                        fail = ERR_VERSION;
                    end
                end
                PH_DOT:
                begin
                    if (data_byte == CH_DOT)
                    begin
                        byte_class       = CLS_VERSION;
                        state_next.phase = PH_MINOR;
                    end
                    else
                    begin
                        fail = ERR_VERSION;
                    end
                end
                PH_MINOR:
                begin
                    if (is_dec_char(data_byte))
                    begin
                        byte_class       = CLS_VERSION;
                        state_next.minor = data_byte[3:0];
                        state_next.phase = PH_SP1;
                    end
                    else
                    begin
                        fail = ERR_VERSION;
                    end
                end
                PH_SP1:
                begin
                    if (data_byte == CH_SP)
                    begin
                        byte_class       = CLS_SEP;
                        state_next.phase = PH_CODE;
                    end
                    else
                    begin
                        fail = ERR_STATUS;
                    end
                end
                PH_CODE:
                begin
                    if (is_dec_char(data_byte))
                    begin
                        byte_class           = CLS_CODE;
                        state_next.code_acc  = acc_next;
                        state_next.digit_cnt = cur.digit_cnt + 2'd1;
                        if (cur.digit_cnt == 2'd2)
                        begin
                            state_next.phase = PH_SP2;
                        end
                    end
                    else
                    begin
                        fail = ERR_STATUS;
                    end
                end
                PH_SP2:
                begin
                    if (data_byte == CH_SP)
                    begin
                        byte_class       = CLS_SEP;
                        state_next.phase = PH_REASON;
                    end
                    else
                    begin
                        fail = ERR_STATUS;
                    end
                end
                PH_REASON:
                begin
                    if (data_byte == CH_CR)
                    begin
                        byte_class       = CLS_LINE_END;
                        state_next.phase = PH_LF;
                    end
                    else if (is_text(data_byte))
                    begin
                        byte_class = CLS_REASON;
                    end
                    else
                    begin
                        fail = ERR_STATUS;
                    end
                end
                PH_LF:
                begin
                    if (cur.digit_cnt == CODE_DIGITS)
                    begin
                        if (data_byte == CH_LF)
                        begin
                            byte_class       = CLS_LINE_END;
                            state_next.phase = PH_LINE;
                        end
                        else
                        begin
                            fail = ERR_STATUS;
                        end
                    end
                    else if (data_byte == CH_LF)
                    begin
                        byte_class       = CLS_HDR_END;
                        state_next.phase = PH_LINE;
                        if (cur.hdr_cnt != HDR_MAX)
                        begin
                            state_next.hdr_cnt = cur.hdr_cnt + 8'd1;
                        end
                    end
                    else
                    begin
                        fail = ERR_HEADER;
                    end
                end
                PH_LINE:
                begin
                    if (data_byte == CH_CR)
                    begin
                        byte_class       = CLS_HDRS_END;
                        state_next.phase = PH_ENDLF;
                    end
                    else if (data_byte == CH_COLON)
                    begin
                        byte_class           = CLS_SEP;
                        state_next.digit_cnt = 2'd0;
                        state_next.phase     = PH_SEPSP;
                    end
                    else if (is_token(data_byte))
                    begin
                        byte_class           = CLS_KEY;
                        state_next.digit_cnt = 2'd0;
                        state_next.phase     = PH_KEY;
                    end
                    else
                    begin
                        fail = ERR_HEADER;
                    end
                end
                PH_KEY:
                begin
                    if (data_byte == CH_COLON)
                    begin
                        byte_class       = CLS_SEP;
                        state_next.phase = PH_SEPSP;
                    end
                    else if (is_token(data_byte))
                    begin
                        byte_class = CLS_KEY;
                    end
                    else
                    begin
                        fail = ERR_HEADER;
                    end
                end
                PH_SEPSP:
                begin
                    if (data_byte == CH_SP)
                    begin
                        byte_class       = CLS_SEP;
                        state_next.phase = PH_VALUE;
                    end
                    else
                    begin
                        fail = ERR_HEADER;
                    end
                end
                PH_VALUE:
                begin
                    if (data_byte == CH_CR)
                    begin
                        byte_class       = CLS_HDR_END;
                        state_next.phase = PH_LF;
                    end
                    else if (is_text(data_byte))
                    begin
                        byte_class = CLS_VALUE;
                    end
                    else
                    begin
                        fail = ERR_HEADER;
                    end
                end
                PH_ENDLF:
                begin
                    if (data_byte == CH_LF)
                    begin
                        byte_class       = CLS_HDRS_END;
                        state_next.phase = PH_BODY;
                    end
                    else
                    begin
                        fail = ERR_HEADER;
                    end
                end
                default:
                begin
                    byte_class = CLS_BODY;
                end
            endcase

            if (fail != ERR_NONE)
            begin
                state_next     = cur;
                state_next.err = fail;
                byte_class     = CLS_REJECT;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/core/http_response_header_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// http_response_header_parser
// Byte tagger for HTTP/1.x response status line and header block.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one response byte per word on s_tdata, s_tuser high
//   on the first byte of a new message (clears counters and error).
//   Master channel: one result word per input word; m_tuser carries the
//   byte tag, m_tdata the status code, version digits, header index and
//   sticky error kind as they stand after this byte (header index before).
//   Path: an accepted input word is held in the input register, then its
//   result is taken into the result register behind the parse-state
//   update logic.
//   Throughput: one word per cycle unless m_tready stalls; the parse state is a
//   single register updated per byte, so a byte follows its predecessor back to back.
//   Reset: all parse state, counters and error clear; no words are held.
//   Stall: when m_tready is low the result register holds, the input
//   register fills, and s_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module http_response_header_parser
    import hrp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] start_of_message
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [9:0] resp_code, [13:10] version_major,
                                        // [17:14] version_minor, [25:18] header_index,
                                        // [27:26] error_kind, [31:28] zero
    output logic [3:0]       m_tuser    // [3:0] byte_class
);

    logic         in_valid_reg;
    logic [7:0]   in_data_reg;
    logic         in_sof_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    logic         out_valid_reg;
    logic [31:0]  out_data_reg;
    logic [3:0]   out_class_reg;
    logic [3:0]   step_class;
    logic [7:0]   step_hdr;
    logic         advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    hrp_step u_step (
        .state            (state_reg),
        .data_byte        (in_data_reg),
        .start_of_message (in_sof_reg),
        .state_next       (state_next),
        .byte_class       (step_class),
        .header_index     (step_hdr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
            in_sof_reg  <= s_tuser;
        end
        if (advance)
        begin
            out_class_reg <= step_class;
            out_data_reg  <= {4'd0, state_next.err, step_hdr, state_next.minor,
                              state_next.major, state_next.code_acc};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_class_reg;

endmodule
`default_nettype wire

[test/http_response_header_parser_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_response_header_parser_checker
// Watches both stream channels of the header parser. For every byte taken on
// the input it computes the tag, status code, version digits, header index
// and sticky error kind. It compares each result word with the oldest one
// still waiting and counts every mismatch.
// ----------------------------------------------------------------------------
module http_response_header_parser_checker
    import hrp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic [3:0]  m_tuser,
    output int               outstanding,
    output int               fail_count
);

    typedef struct packed {
        logic [3:0] byte_class;
        logic [9:0] resp_code;
        logic [3:0] ver_major;
        logic [3:0] ver_minor;
        logic [7:0] header_index;
        logic [1:0] error_kind;
    } byte_tag_t;

    logic [3:0] phase;
    logic [9:0] code_acc;
    logic [1:0] digit_cnt;
    logic [3:0] major_ver;
    logic [3:0] minor_ver;
    logic [7:0] header_cnt;
    logic [1:0] sticky_err;

    byte_tag_t  pending_tags[$];
    byte_tag_t  oldest;

    function automatic logic is_decimal(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_field_text(input logic [7:0] c);
        return c == 8'h09 || (c >= 8'h20 && c <= 8'h7E) || c >= 8'h80;
    endfunction

    function automatic logic is_key_char(input logic [7:0] c);
        if (is_decimal(c) || (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A))
        begin
            return 1'b1;
        end
        case (c)
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
            8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void clear_parse_state();
        phase      = PH_LETTERS;
        code_acc   = '0;
        digit_cnt  = '0;
        major_ver  = '0;
        minor_ver  = '0;
        header_cnt = '0;
        sticky_err = ERR_NONE;
    endfunction

    function automatic byte_tag_t tag_byte(input logic [7:0] c, input logic som);
        byte_tag_t  r;
        logic [3:0] cls;
        logic [1:0] fault;
        logic [7:0] index_before;
        logic [7:0] letter;
        if (som)
        begin
            clear_parse_state();
        end
        index_before = header_cnt;
        cls = CLS_REJECT;
        fault = ERR_NONE;
        letter = (digit_cnt == 2'd0) ? CH_H : (digit_cnt == 2'd3) ? CH_P : CH_T;
        if (sticky_err == ERR_NONE)
        begin
            case (phase)
                PH_LETTERS:
                    if (c == letter)
                    begin
                        cls = CLS_VERSION;
                        if (digit_cnt == 2'd3)
                        begin
                            digit_cnt = '0;
                            phase = PH_SLASH;
                        end
                        else
                        begin
                            digit_cnt = digit_cnt + 2'd1;
                        end
                    end
                    else fault = ERR_VERSION;
                PH_SLASH:
                    if (c == CH_SLASH)
                    begin
                        cls = CLS_VERSION;
                        phase = PH_MAJOR;
                    end
                    else fault = ERR_VERSION;
                PH_MAJOR:
                    if (is_decimal(c))
                    begin
                        cls = CLS_VERSION;
                        major_ver = c[3:0];
                        phase = PH_DOT;
                    end
                    else fault = ERR_VERSION;
                PH_DOT:
                    if (c == CH_DOT)
                    begin
                        cls = CLS_VERSION;
                        phase = PH_MINOR;
                    end
                    else fault = ERR_VERSION;
                PH_MINOR:
                    if (is_decimal(c))
                    begin
                        cls = CLS_VERSION;
                        minor_ver = c[3:0];
                        phase = PH_SP1;
                    end
                    else fault = ERR_VERSION;
                PH_SP1:
                    if (c == CH_SP)
                    begin
                        cls = CLS_SEP;
                        phase = PH_CODE;
                    end
                    else fault = ERR_STATUS;
                PH_CODE:
                    if (is_decimal(c))
                    begin
                        cls = CLS_CODE;
                        code_acc = 10'(code_acc * 10 + c[3:0]);
                        digit_cnt = digit_cnt + 2'd1;
                        if (digit_cnt == CODE_DIGITS) phase = PH_SP2;
                    end
                    else fault = ERR_STATUS;
                PH_SP2:
                    if (c == CH_SP)
                    begin
                        cls = CLS_SEP;
                        phase = PH_REASON;
                    end
                    else fault = ERR_STATUS;
                PH_REASON:
                    if (c == CH_CR)
                    begin
                        cls = CLS_LINE_END;
                        phase = PH_LF;
                    end
                    else if (is_field_text(c)) cls = CLS_REASON;
                    else fault = ERR_STATUS;
                PH_LF:
                    if (digit_cnt == CODE_DIGITS)
                    begin
                        if (c == CH_LF)
                        begin
                            cls = CLS_LINE_END;
                            phase = PH_LINE;
                        end
                        else fault = ERR_STATUS;
                    end
                    else if (c == CH_LF)
                    begin
                        cls = CLS_HDR_END;
                        phase = PH_LINE;
                        if (header_cnt != HDR_MAX) header_cnt = header_cnt + 8'd1;
                    end
                    else fault = ERR_HEADER;
                PH_LINE:
                    if (c == CH_CR)
                    begin
                        cls = CLS_HDRS_END;
                        phase = PH_ENDLF;
                    end
                    else if (c == CH_COLON)
                    begin
                        cls = CLS_SEP;
                        digit_cnt = '0;
                        phase = PH_SEPSP;
                    end
                    else if (is_key_char(c))
                    begin
                        cls = CLS_KEY;
                        digit_cnt = '0;
                        phase = PH_KEY;
                    end
                    else fault = ERR_HEADER;
                PH_KEY:
                    if (c == CH_COLON)
                    begin
                        cls = CLS_SEP;
                        phase = PH_SEPSP;
                    end
                    else if (is_key_char(c)) cls = CLS_KEY;
                    else fault = ERR_HEADER;
                PH_SEPSP:
                    if (c == CH_SP)
                    begin
                        cls = CLS_SEP;
                        phase = PH_VALUE;
                    end
                    else fault = ERR_HEADER;
                PH_VALUE:
                    if (c == CH_CR)
                    begin
                        cls = CLS_HDR_END;
                        phase = PH_LF;
                    end
                    else if (is_field_text(c)) cls = CLS_VALUE;
                    else fault = ERR_HEADER;
                PH_ENDLF:
                    if (c == CH_LF)
                    begin
                        cls = CLS_HDRS_END;
                        phase = PH_BODY;
                    end
                    else fault = ERR_HEADER;
                default:
                    cls = CLS_BODY;
            endcase
            if (fault != ERR_NONE)
            begin
                sticky_err = fault;
                cls = CLS_REJECT;
            end
        end
        r.byte_class   = cls;
        r.resp_code    = code_acc;
        r.ver_major    = major_ver;
        r.ver_minor    = minor_ver;
        r.header_index = index_before;
        r.error_kind   = sticky_err;
        return r;
    endfunction

    task automatic compare_field(input string label, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parse_state();
            pending_tags.delete();
            fail_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_tags.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, actual tag %0d data %h",
                             $time, m_tuser, m_tdata);
                    fail_count++;
                end
                else
                begin
                    oldest = pending_tags.pop_front();
                    compare_field("byte_class", oldest.byte_class, m_tuser);
                    compare_field("resp_code", oldest.resp_code, m_tdata[9:0]);
                    compare_field("version_major", oldest.ver_major, m_tdata[13:10]);
                    compare_field("version_minor", oldest.ver_minor, m_tdata[17:14]);
                    compare_field("header_index", oldest.header_index, m_tdata[25:18]);
                    compare_field("error_kind", oldest.error_kind, m_tdata[27:26]);
                end
            end
            if (s_tvalid && s_tready)
            begin
                pending_tags.insert(pending_tags.size(), tag_byte(s_tdata, s_tuser));
            end
            outstanding <= pending_tags.size();
        end
    end

endmodule

[test/http_response_header_parser_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_response_header_parser_test
// Drives HTTP responses byte by byte into the header parser: a short directed
// message, a long header block that saturates the header index, then random
// well-formed, corrupted, truncated and noise messages under several idle and
// stall patterns. The checker beside the parser predicts and compares.
// ----------------------------------------------------------------------------
module http_response_header_parser_test;
    import hrp_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_QUOTA  = 160;
    localparam int LONG_HEADERS = 260;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam string TOKEN_SET =
        "!#$%&'*+-.^_|~0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [3:0]  m_tuser;

    int outstanding;
    int fail_count;
    int words_sent;
    int cycle_count;
    int tx_idle_pct;
    int rx_stall_pct;
    int hold_requests;
    int hold_served;

    http_response_header_parser DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    http_response_header_parser_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    initial clk = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: random stall, or a long hold-off when one is requested
    initial
    begin
        m_tready = 1'b0;
        hold_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_served++;
            end
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    function automatic logic [7:0] rand_text_char();
        case ($urandom_range(0, 3))
            0: return 8'h09;
            1, 2: return 8'($urandom_range(32, 126));
            default: return 8'($urandom_range(128, 255));
        endcase
    endfunction

    function automatic logic [7:0] rand_key_char();
        if ($urandom_range(0, 40) == 0)
        begin
            return 8'h60;
        end
        return TOKEN_SET[$urandom_range(0, TOKEN_SET.len() - 1)];
    endfunction

    task automatic push_text(ref logic [7:0] msg[$], input string s);
        for (int i = 0; i < s.len(); i++) msg.insert(msg.size(), s[i]);
    endtask

    task automatic push_line_end(ref logic [7:0] msg[$]);
        msg.insert(msg.size(), CH_CR);
        msg.insert(msg.size(), CH_LF);
    endtask

    task automatic compose_response(ref logic [7:0] msg[$]);
        int n_hdr;
        msg.delete();
        push_text(msg, "HTTP/");
        msg.insert(msg.size(), CH_ZERO + 8'($urandom_range(0, 9)));
        msg.insert(msg.size(), CH_DOT);
        msg.insert(msg.size(), CH_ZERO + 8'($urandom_range(0, 9)));
        msg.insert(msg.size(), CH_SP);
        repeat (3) msg.insert(msg.size(), CH_ZERO + 8'($urandom_range(0, 9)));
        msg.insert(msg.size(), CH_SP);
        repeat ($urandom_range(0, 6)) msg.insert(msg.size(), rand_text_char());
        push_line_end(msg);
        n_hdr = $urandom_range(0, 4);
        repeat (n_hdr)
        begin
            repeat ($urandom_range(0, 5)) msg.insert(msg.size(), rand_key_char());
            msg.insert(msg.size(), CH_COLON);
            msg.insert(msg.size(), CH_SP);
            repeat ($urandom_range(0, 6)) msg.insert(msg.size(), rand_text_char());
            push_line_end(msg);
        end
        push_line_end(msg);
        repeat ($urandom_range(0, 5)) msg.insert(msg.size(), 8'($urandom_range(0, 255)));
    endtask

    task automatic send_word(input logic [7:0] b, input logic som);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= som;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        words_sent++;
    endtask

    task automatic send_message(ref logic [7:0] msg[$]);
        for (int i = 0; i < msg.size(); i++) send_word(msg[i], i == 0);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic send_random_message();
        logic [7:0] msg[$];
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            repeat ($urandom_range(1, 8))
                send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        else
        begin
            compose_response(msg);
            if (kind < 35)
            begin
                msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom_range(0, 255));
            end
            else if (kind < 45)
            begin
                msg = msg[0:$urandom_range(0, msg.size() - 1)];
            end
            send_message(msg);
        end
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct);
        int first;
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        first = words_sent;
        while (words_sent - first < PHASE_QUOTA) send_random_message();
        drain();
    endtask

    initial
    begin
        logic [7:0] msg[$];
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        words_sent = 0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_requests = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty reason, empty key and value, extreme version and code digits
        push_text(msg, "HTTP/0.9 999 ");
        push_line_end(msg);
        push_text(msg, ": ");
        push_line_end(msg);
        push_line_end(msg);
        msg.insert(msg.size(), 8'hFF);
        send_message(msg);
        msg.delete();
        push_text(msg, "HTTQx");
        send_message(msg);
        drain();

        // long hold-off on the result side while bytes keep coming
        hold_requests <= hold_requests + 1;
        compose_response(msg);
        send_message(msg);
        drain();

        // header index runs into saturation
        msg.delete();
        push_text(msg, "HTTP/1.1 200 OK");
        push_line_end(msg);
        repeat (LONG_HEADERS)
        begin
            msg.insert(msg.size(), CH_COLON);
            msg.insert(msg.size(), CH_SP);
            push_line_end(msg);
        end
        push_line_end(msg);
        send_message(msg);
        drain();

        run_phase(0, 0);
        run_phase(76, 0);
        run_phase(0, 76);
        run_phase(20, 20);

        repeat (10) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
